// ----- src/i2cm_pkg.sv -----
`timescale 1ns / 1ps

package i2cm_pkg;

    // request codes
    localparam logic [2:0] REQ_NONE       = 3'd0;
    localparam logic [2:0] REQ_RESET      = 3'd1;
    localparam logic [2:0] REQ_READ_CFG   = 3'd2;
    localparam logic [2:0] REQ_READ_SMP   = 3'd3;
    localparam logic [2:0] REQ_WRITE_CFG  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_DEV_ADDR    = 3'd0;
    localparam logic [2:0] CFG_BUS_FREE    = 3'd1;
    localparam logic [2:0] CFG_START_HOLD  = 3'd2;
    localparam logic [2:0] CFG_DATA_SETUP  = 3'd3;
    localparam logic [2:0] CFG_DATA_HOLD   = 3'd4;
    localparam logic [2:0] CFG_CLK_LOW     = 3'd5;
    localparam logic [2:0] CFG_CLK_HIGH    = 3'd6;
    localparam logic [2:0] CFG_STOP_SETUP  = 3'd7;

    // bytes of the general-call reset and register pointers
    localparam logic [7:0] GC_ADDR_BYTE  = 8'h00;
    localparam logic [7:0] GC_RESET_BYTE = 8'h06;
    localparam logic [7:0] PTR_CONFIG    = 8'h01;
    localparam logic [7:0] PTR_SAMPLE    = 8'h00;
    localparam logic [7:0] MSB_MASK      = 8'h80;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_FREE  = 5'd1,
        PH_ST_HOLD  = 5'd2,
        PH_TX_HOLD  = 5'd3,
        PH_TX_SETUP = 5'd4,
        PH_TX_REST  = 5'd5,
        PH_TX_HIGH  = 5'd6,
        PH_RX_LOW   = 5'd7,
        PH_RX_SETUP = 5'd8,
        PH_RX_REST  = 5'd9,
        PH_SP_LOW   = 5'd10,
        PH_SP_HIGH  = 5'd11
    } t_phase;

    typedef struct packed {
        logic [6:0]  dev_addr;
        logic [15:0] bus_free;
        logic [15:0] start_hold;
        logic [15:0] data_setup;
        logic [15:0] data_hold;
        logic [15:0] clk_low;
        logic [15:0] clk_high;
        logic [15:0] stop_setup;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  byte_idx;
        logic [3:0]  bit_idx;
        logic [15:0] tick_cnt;
        logic [15:0] shreg;
        logic        sda_drv;
        logic [2:0]  cmd;
        logic [3:0]  nack;
    } t_st;

    // result of one tick toward the output stage
    typedef struct packed {
        logic        scl_low;
        logic        sda_low;
        logic        busy;
        logic        done;
        logic [15:0] read_word;
        logic [3:0]  nack;
    } t_res;

    function automatic logic is_read(t_st s);
        return (s.cmd == REQ_READ_CFG) || (s.cmd == REQ_READ_SMP);
    endfunction

    function automatic logic is_recv(t_st s);
        return is_read(s) && (s.byte_idx >= 3'd3);
    endfunction

    function automatic logic [7:0] send_byte(t_st s, t_cfg c);
        logic [7:0] a;
        a = {c.dev_addr, 1'b0};
        unique case (s.cmd)
            REQ_RESET: begin
                return (s.byte_idx == 3'd0) ? GC_ADDR_BYTE : GC_RESET_BYTE;
            end
            REQ_READ_CFG, REQ_READ_SMP: begin
                if (s.byte_idx == 3'd0) return a;
                if (s.byte_idx == 3'd1)
                    return (s.cmd == REQ_READ_CFG) ? PTR_CONFIG : PTR_SAMPLE;
                return a | 8'h01;
            end
            REQ_WRITE_CFG: begin
                if (s.byte_idx == 3'd0) return a;
                if (s.byte_idx == 3'd1) return PTR_CONFIG;
                if (s.byte_idx == 3'd2) return s.shreg[15:8];
                return s.shreg[7:0];
            end
            default: return 8'hFF;
        endcase
    endfunction

    // 1 pulls sda low for the current bit
    function automatic logic next_low(t_st s, t_cfg c);
        logic [7:0] b;
        b = send_byte(s, c);
        if (is_recv(s)) return 1'b1;
        if (s.bit_idx >= 4'd8) return 1'b0;
        return ((b & (MSB_MASK >> s.bit_idx[2:0])) == 8'h00);
    endfunction

    function automatic t_st begin_send(t_st s, t_cfg c);
        t_st r;
        r = s;
        if (next_low(s, c) != s.sda_drv) begin
            r.phase    = PH_TX_HOLD;
            r.tick_cnt = c.data_hold;
        end else begin
            r.phase    = PH_TX_REST;
            r.tick_cnt = c.clk_low;
        end
        return r;
    endfunction

    function automatic t_st begin_recv(t_st s, t_cfg c);
        t_st r;
        r = s;
        r.sda_drv  = 1'b0;
        r.phase    = PH_RX_LOW;
        r.tick_cnt = c.clk_low;
        return r;
    endfunction

    function automatic t_st begin_item(t_st s, t_cfg c);
        if (is_recv(s) == (s.bit_idx < 4'd8)) return begin_recv(s, c);
        return begin_send(s, c);
    endfunction

    function automatic t_st begin_stop(t_st s, t_cfg c);
        t_st r;
        r = s;
        r.sda_drv  = 1'b1;
        r.phase    = PH_SP_LOW;
        r.tick_cnt = (c.clk_low > c.data_setup) ? c.clk_low : c.data_setup;
        return r;
    endfunction

    function automatic t_st finish_bit(t_st s, t_cfg c);
        t_st r;
        logic stop;
        r = s;
        r.bit_idx = s.bit_idx + 4'd1;
        if (r.bit_idx < 4'd9) return begin_item(r, c);
        r.bit_idx  = 4'd0;
        r.byte_idx = s.byte_idx + 3'd1;
        stop = ((r.cmd == REQ_RESET) && (r.byte_idx == 3'd2)) ||
               (is_read(r) && ((r.byte_idx == 3'd2) || (r.byte_idx == 3'd5))) ||
               ((r.cmd == REQ_WRITE_CFG) && (r.byte_idx == 3'd4)) ||
               (r.byte_idx >= 3'd5);
        if (stop) return begin_stop(r, c);
        return begin_item(r, c);
    endfunction

    function automatic logic adv_done(t_st s);
        return (s.phase == PH_SP_HIGH) && !(is_read(s) && (s.byte_idx == 3'd2));
    endfunction

    // one phase transition of the bus sequencer
    function automatic t_st advance(t_st s, t_cfg c, logic sda);
        t_st r;
        logic [16:0] hs;
        r = s;
        hs = {1'b0, c.data_hold} + {1'b0, c.data_setup};
        unique case (s.phase)
            PH_ST_FREE: begin
                r.sda_drv  = 1'b1;
                r.phase    = PH_ST_HOLD;
                r.tick_cnt = c.start_hold;
            end
            PH_ST_HOLD: r = begin_item(s, c);
            PH_TX_HOLD: begin
                r.sda_drv  = next_low(s, c);
                r.phase    = PH_TX_SETUP;
                r.tick_cnt = c.data_setup;
            end
            PH_TX_SETUP: begin
                r.phase    = PH_TX_REST;
                r.tick_cnt = ({1'b0, c.clk_low} > hs) ? c.clk_low - hs[15:0] : 16'd0;
            end
            PH_TX_REST: begin
                r.phase    = PH_TX_HIGH;
                r.tick_cnt = c.clk_high;
            end
            PH_TX_HIGH: r = finish_bit(s, c);
            PH_RX_LOW: begin
                r.phase    = PH_RX_SETUP;
                r.tick_cnt = c.data_setup;
            end
            PH_RX_SETUP: begin
                if (s.bit_idx < 4'd8) begin
                    if (is_recv(s)) r.shreg = {s.shreg[14:0], sda};
                end else if (!is_recv(s) && sda && (s.byte_idx < 3'd4)) begin
                    r.nack[s.byte_idx[1:0]] = 1'b1;
                end
                r.phase    = PH_RX_REST;
                r.tick_cnt = (c.clk_high > c.data_setup) ? c.clk_high - c.data_setup : 16'd0;
            end
            PH_RX_REST: r = finish_bit(s, c);
            PH_SP_LOW: begin
                r.phase    = PH_SP_HIGH;
                r.tick_cnt = c.stop_setup;
            end
            PH_SP_HIGH: begin
                r.sda_drv = 1'b0;
                if (is_read(s) && (s.byte_idx == 3'd2)) begin
                    r.phase    = PH_ST_FREE;
                    r.tick_cnt = c.bus_free;
                end else begin
                    r.phase    = PH_IDLE;
                    r.tick_cnt = 16'd0;
                end
            end
            default: begin
                r.phase    = PH_IDLE;
                r.tick_cnt = 16'd0;
                r.sda_drv  = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- src/i2cm_seq.sv -----
`timescale 1ns / 1ps

module i2cm_seq import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [2:0]  i_req,
    input  logic [15:0] i_word,
    input  logic        i_sda,
    input  t_cfg        i_cfg,
    input  logic        i_take,
    output logic        o_fin,
    output t_res        o_res
);

    t_st  r_st, n_st;
    logic r_mid, n_mid;
    logic r_done_acc, n_done_acc;

    t_st  w_st, a_st, f_st;
    logic need_adv, done_now, fin;

    // tick front: a request is taken only on the first pass of a tick
    always_comb begin
        w_st = r_st;
        if (!r_mid && (r_st.phase == PH_IDLE) && (i_req >= REQ_RESET) &&
            (i_req <= REQ_WRITE_CFG)) begin
            w_st.cmd      = i_req;
            w_st.nack     = 4'd0;
            w_st.shreg    = (i_req == REQ_WRITE_CFG) ? i_word : 16'd0;
            w_st.byte_idx = 3'd0;
            w_st.bit_idx  = 4'd0;
            w_st.sda_drv  = 1'b0;
            w_st.phase    = PH_ST_FREE;
            w_st.tick_cnt = i_cfg.bus_free;
        end
        if (r_mid) w_st = r_st;
    end

    // one phase step, then decide whether this tick ends here
    always_comb begin
        need_adv = (w_st.phase != PH_IDLE) && (w_st.tick_cnt == 16'd0);
        a_st     = need_adv ? advance(w_st, i_cfg, i_sda) : w_st;
        done_now = need_adv && adv_done(w_st);
        fin      = !((a_st.phase != PH_IDLE) && (a_st.tick_cnt == 16'd0));
        f_st     = a_st;
        if (a_st.phase != PH_IDLE) f_st.tick_cnt = a_st.tick_cnt - 16'd1;
    end

    // result of the finished tick
    always_comb begin
        o_fin           = i_valid && fin;
        o_res.scl_low   = !((f_st.phase == PH_IDLE) || (f_st.phase == PH_ST_FREE) ||
                            (f_st.phase == PH_ST_HOLD) || (f_st.phase == PH_TX_HIGH) ||
                            (f_st.phase == PH_RX_SETUP) || (f_st.phase == PH_RX_REST) ||
                            (f_st.phase == PH_SP_HIGH));
        o_res.sda_low   = f_st.sda_drv;
        o_res.busy      = (f_st.phase != PH_IDLE);
        o_res.done      = r_done_acc || done_now;
        o_res.read_word = is_read(f_st) ? f_st.shreg : 16'd0;
        o_res.nack      = f_st.nack;
    end

    // next state
    always_comb begin
        n_st       = r_st;
        n_mid      = r_mid;
        n_done_acc = r_done_acc;
        if (i_valid) begin
            if (!fin) begin
                n_st       = a_st;
                n_mid      = 1'b1;
                n_done_acc = r_done_acc || done_now;
            end else if (i_take) begin
                n_st       = f_st;
                n_mid      = 1'b0;
                n_done_acc = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= '{phase: PH_IDLE, default: '0};
            r_mid      <= 1'b0;
            r_done_acc <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_mid      <= n_mid;
            r_done_acc <= n_done_acc;
        end
    end

    // an unfinished tick keeps its item in the input stage
    a_mid_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> i_valid)
        else $error("step chain running without an item");

    // sda is released whenever the bus is idle
    a_idle_sda: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == PH_IDLE) |-> !r_st.sda_drv)
        else $error("sda held low while idle");

    // done only closes a transaction
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_fin && o_res.done) |-> !o_res.busy)
        else $error("done while still busy");

    // bit counter never runs past the acknowledge slot
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.bit_idx <= 4'd8)
        else $error("bit index out of range");

endmodule

// ----- src/i2c_adc_transaction_master_top.sv -----
`timescale 1ns / 1ps

// Tick-driven open-drain I2C master for a 16-bit ADC register device. Each
// input transfer is one bus tick carrying a request code (tuser) and the
// sampled SDA level; each tick yields one output transfer with SCL/SDA drive,
// busy, done, the read word and per-byte NACK flags. A new tick is accepted
// every cycle while the last tick has finished and the output stage is free.
// When timing registers of zero let several bus phases pass in one tick, the
// phase stepper runs one phase per cycle and holds the tick until it ends.
// Timing registers are written through the configuration port while the
// block is idle; the user must keep to this, the block does not enforce it.
module i2c_adc_transaction_master_top import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // write_word[15:0], sda_in[16], zero pad
    input  logic [2:0]  i_s_tuser,   // req_type[2:0]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // scl_drive_low[0], sda_drive_low[1], busy_res[2],
                                     // done_res[3], read_word[19:4], nack_flags[23:20]
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg r_cfg;

    logic        r_in_valid;
    logic [2:0]  r_req;
    logic [15:0] r_word;
    logic        r_sda;

    logic        r_out_valid;
    t_res        r_out;

    logic        out_free, fin, s_acc;
    t_res        res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr   <= 7'd72;
            r_cfg.bus_free   <= 16'd5;
            r_cfg.start_hold <= 16'd5;
            r_cfg.data_setup <= 16'd1;
            r_cfg.data_hold  <= 16'd1;
            r_cfg.clk_low    <= 16'd5;
            r_cfg.clk_high   <= 16'd5;
            r_cfg.stop_setup <= 16'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEV_ADDR:   r_cfg.dev_addr   <= i_cfg_wdata[6:0];
                CFG_BUS_FREE:   r_cfg.bus_free   <= i_cfg_wdata;
                CFG_START_HOLD: r_cfg.start_hold <= i_cfg_wdata;
                CFG_DATA_SETUP: r_cfg.data_setup <= i_cfg_wdata;
                CFG_DATA_HOLD:  r_cfg.data_hold  <= i_cfg_wdata;
                CFG_CLK_LOW:    r_cfg.clk_low    <= i_cfg_wdata;
                CFG_CLK_HIGH:   r_cfg.clk_high   <= i_cfg_wdata;
                CFG_STOP_SETUP: r_cfg.stop_setup <= i_cfg_wdata;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // handshake glue
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || (fin && out_free);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (fin && out_free) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_req  <= i_s_tuser;
            r_word <= i_s_tdata[15:0];
            r_sda  <= i_s_tdata[16];
        end
    end

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_req   (r_req),
        .i_word  (r_word),
        .i_sda   (r_sda),
        .i_cfg   (r_cfg),
        .i_take  (out_free),
        .o_fin   (fin),
        .o_res   (res)
    );

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin && out_free) r_out <= res;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.nack, r_out.read_word, r_out.done, r_out.busy,
                         r_out.sda_low, r_out.scl_low};

endmodule
